// File: design/lav_pkg.sv
// Shared widths, types and prescale helpers for the look-at view matrix pipeline.
`default_nettype none
package lav_pkg;
	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int VEC_W     = 50;
	localparam int MAG_W     = VEC_W;
	localparam int POS_W     = 6;
	localparam int SM_W      = 30;
	localparam int SUM_W     = 2 * SM_W + 2;
	localparam int LEN_W     = SUM_W / 2;
	localparam int Q_W       = FRAC_BITS + 1;
	localparam int UNIT_W    = FRAC_BITS + 2;
	localparam int U_W       = UNIT_W + 2;
	localparam int DP_W      = U_W + COORD_W + 2;
	localparam int HALF_LSB  = 1 << (FRAC_BITS - 1);
	localparam int NORM_LAT  = 6 + LEN_W + 1 + Q_W + 1;

	typedef logic signed [VEC_W-1:0]   vcomp_t;
	typedef logic signed [UNIT_W-1:0]  unit_t;
	typedef logic        [MAG_W-1:0]   mag_t;
	typedef logic        [SM_W-1:0]    smag_t;
	typedef logic signed [COORD_W-1:0] coord_t;

	function automatic mag_t mag_of(input vcomp_t x);
		return x[VEC_W-1] ? mag_t'(-x) : mag_t'(x);
	endfunction

	function automatic logic [POS_W-1:0] msb_pos(input mag_t m);
		logic [POS_W-1:0] p;
		p = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (m[i]) p = POS_W'(i);
		end
		return p;
	endfunction

	// largest magnitude lands in [2^29, 2^30); right shifts truncate
	function automatic smag_t scale_mag(input mag_t m, input logic [POS_W-1:0] p);
		mag_t t;
		if (p >= POS_W'(SM_W)) begin
			t = m >> (p - POS_W'(SM_W - 1));
		end else begin
			t = m << (POS_W'(SM_W - 1) - p);
		end
		return t[SM_W-1:0];
	endfunction
endpackage
`default_nettype wire

// File: design/lav_norm.sv
// Pipelined vector normalizer: prescale, bit-per-stage square root, bit-per-stage divide.
`default_nettype none
module lav_norm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  lav_pkg::vcomp_t in_vec [3],
	output logic            out_valid,
	output lav_pkg::unit_t  out_vec [3],
	output logic            out_ok
);
	import lav_pkg::*;

	localparam int SQ_W  = 2 * SM_W;
	localparam int TR_W  = SUM_W + 2;
	localparam int DEN_W = LEN_W + 1;
	localparam int DR_W  = SM_W + Q_W + 2;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	mag_t mag_s1 [3];
	mag_t mag_s2 [3];
	mag_t mag_s3 [3];
	logic [2:0] neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	mag_t mx_s2, mx_c;
	logic [POS_W-1:0] pos_s3;
	logic ok_s3, ok_s4, ok_s5;
	smag_t sm_s4 [3];
	smag_t sm_s5 [3];
	logic [SQ_W-1:0] sq_s5 [3];

	logic              vld_sq  [LEN_W+1];
	logic [SUM_W-1:0]  rem_sq  [LEN_W+1];
	logic [LEN_W-1:0]  root_sq [LEN_W+1];
	smag_t             sm_sq   [LEN_W+1][3];
	logic [2:0]        neg_sq  [LEN_W+1];
	logic              ok_sq   [LEN_W+1];
	logic [TR_W-1:0]   trial_sq [LEN_W];
	logic [LEN_W-1:0]  take_sq;

	logic              vld_dv [Q_W+1];
	logic [DR_W-1:0]   rem_dv [Q_W+1][3];
	logic [Q_W-1:0]    quo_dv [Q_W+1][3];
	logic [DEN_W-1:0]  den_dv [Q_W+1];
	logic [2:0]        neg_dv [Q_W+1];
	logic              ok_dv  [Q_W+1];
	logic [DR_W-1:0]   dtr_dv [Q_W];
	logic [2:0]        take_dv [Q_W];

	logic   out_valid_q, out_ok_q;
	unit_t  out_vec_q [3];

	always_comb begin
		mx_c = mag_s1[0];
		if (mag_s1[1] > mx_c) mx_c = mag_s1[1];
		if (mag_s1[2] > mx_c) mx_c = mag_s1[2];
	end

	always_comb begin
		for (int k = 0; k < LEN_W; k++) begin
			trial_sq[k] = (TR_W'(root_sq[k]) << (LEN_W - k))
				+ (TR_W'(1) << (2 * (LEN_W - 1 - k)));
			take_sq[k] = TR_W'(rem_sq[k]) >= trial_sq[k];
		end
		for (int k = 0; k < Q_W; k++) begin
			dtr_dv[k] = DR_W'(den_dv[k]) << (Q_W - 1 - k);
			for (int i = 0; i < 3; i++) take_dv[k][i] = rem_dv[k][i] >= dtr_dv[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int k = 0; k <= LEN_W; k++) vld_sq[k] <= 1'b0;
			for (int k = 0; k <= Q_W; k++) vld_dv[k] <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			vld_sq[0] <= v_s5;
			for (int k = 0; k < LEN_W; k++) vld_sq[k+1] <= vld_sq[k];
			vld_dv[0] <= vld_sq[LEN_W];
			for (int k = 0; k < Q_W; k++) vld_dv[k+1] <= vld_dv[k];
			out_valid_q <= vld_dv[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= mag_of(in_vec[i]);
			neg_s1[i] <= in_vec[i][VEC_W-1];
		end
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
		mx_s2  <= mx_c;
		mag_s3 <= mag_s2;
		neg_s3 <= neg_s2;
		pos_s3 <= msb_pos(mx_s2);
		ok_s3  <= mx_s2 != '0;
		for (int i = 0; i < 3; i++) sm_s4[i] <= scale_mag(mag_s3[i], pos_s3);
		neg_s4 <= neg_s3;
		ok_s4  <= ok_s3;
		for (int i = 0; i < 3; i++) sq_s5[i] <= SQ_W'(sm_s4[i]) * SQ_W'(sm_s4[i]);
		sm_s5  <= sm_s4;
		neg_s5 <= neg_s4;
		ok_s5  <= ok_s4;

		rem_sq[0]  <= SUM_W'(sq_s5[0]) + SUM_W'(sq_s5[1]) + SUM_W'(sq_s5[2]);
		root_sq[0] <= '0;
		sm_sq[0]   <= sm_s5;
		neg_sq[0]  <= neg_s5;
		ok_sq[0]   <= ok_s5;
		for (int k = 0; k < LEN_W; k++) begin
			rem_sq[k+1]  <= take_sq[k] ? rem_sq[k] - trial_sq[k][SUM_W-1:0] : rem_sq[k];
			root_sq[k+1] <= root_sq[k] | (LEN_W'(take_sq[k]) << (LEN_W - 1 - k));
			sm_sq[k+1]   <= sm_sq[k];
			neg_sq[k+1]  <= neg_sq[k];
			ok_sq[k+1]   <= ok_sq[k];
		end

		for (int i = 0; i < 3; i++) begin
			rem_dv[0][i] <= DR_W'({sm_sq[LEN_W][i], {Q_W{1'b0}}}) + DR_W'(root_sq[LEN_W]);
			quo_dv[0][i] <= '0;
		end
		den_dv[0] <= {root_sq[LEN_W], 1'b0};
		neg_dv[0] <= neg_sq[LEN_W];
		ok_dv[0]  <= ok_sq[LEN_W];
		for (int k = 0; k < Q_W; k++) begin
			for (int i = 0; i < 3; i++) begin
				rem_dv[k+1][i] <= take_dv[k][i] ? rem_dv[k][i] - dtr_dv[k] : rem_dv[k][i];
				quo_dv[k+1][i] <= quo_dv[k][i] | (Q_W'(take_dv[k][i]) << (Q_W - 1 - k));
			end
			den_dv[k+1] <= den_dv[k];
			neg_dv[k+1] <= neg_dv[k];
			ok_dv[k+1]  <= ok_dv[k];
		end

		for (int i = 0; i < 3; i++) begin
			if (!ok_dv[Q_W]) begin
				out_vec_q[i] <= '0;
			end else if (neg_dv[Q_W][i]) begin
				out_vec_q[i] <= -unit_t'({1'b0, quo_dv[Q_W][i]});
			end else begin
				out_vec_q[i] <= unit_t'({1'b0, quo_dv[Q_W][i]});
			end
		end
		out_ok_q <= ok_dv[Q_W];
	end

	assign out_valid = out_valid_q;
	assign out_vec   = out_vec_q;
	assign out_ok    = out_ok_q;
endmodule
`default_nettype wire

// File: design/look_at_view_matrix_top.sv
// Top level of the look-at view matrix pipeline: datapath, row sequencer and start/busy port.
`default_nettype none
// An item is taken when start is high and busy is low; busy then stays high until the gap
// counter runs down, so a new item is not taken before the single result port has room for
// the four rows. Rows 0 to 3 appear on consecutive cycles, each marked by strobe; the two
// normalizers (31 square root stages and 17 divide stages each) make up most of the path
// from the accepting edge to row 0. Results cannot be held off and must be taken as
// they come. degenerate is the same on all four rows of an item.
module look_at_view_matrix_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [lav_pkg::COORD_W-1:0] eye_x,
	input  logic signed [lav_pkg::COORD_W-1:0] eye_y,
	input  logic signed [lav_pkg::COORD_W-1:0] eye_z,
	input  logic signed [lav_pkg::COORD_W-1:0] target_x,
	input  logic signed [lav_pkg::COORD_W-1:0] target_y,
	input  logic signed [lav_pkg::COORD_W-1:0] target_z,
	input  logic signed [lav_pkg::COORD_W-1:0] up_x,
	input  logic signed [lav_pkg::COORD_W-1:0] up_y,
	input  logic signed [lav_pkg::COORD_W-1:0] up_z,
	output logic                            strobe,
	output logic [1:0]                      row_index,
	output logic signed [lav_pkg::COORD_W-1:0] col0,
	output logic signed [lav_pkg::COORD_W-1:0] col1,
	output logic signed [lav_pkg::COORD_W-1:0] col2,
	output logic signed [lav_pkg::COORD_W-1:0] col3,
	output logic                            degenerate,
	output logic                            last_row
);
	import lav_pkg::*;

	localparam logic [1:0] ROW_SIDE   = 2'd0;
	localparam logic [1:0] ROW_UP     = 2'd1;
	localparam logic [1:0] ROW_FWD    = 2'd2;
	localparam logic [1:0] ROW_ORIGIN = 2'd3;
	localparam logic [1:0] GAP_CYCLES = 2'd3;
	localparam int PF_W = UNIT_W + SM_W + 1;
	localparam int UD_W = 2 * UNIT_W + 1;
	localparam coord_t ONE_Q = coord_t'(1 << FRAC_BITS);
	localparam logic signed [DP_W:0] T_MAX = (DP_W+1)'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
	localparam logic signed [DP_W:0] T_MIN = -T_MAX - 1;

	function automatic coord_t tr_out(input logic signed [DP_W-1:0] acc, input logic negate);
		logic signed [DP_W:0] t;
		t = (DP_W+1)'(acc) + (DP_W+1)'(HALF_LSB);
		t = t >>> FRAC_BITS;
		if (negate) t = -t;
		if (t > T_MAX) return T_MAX[COORD_W-1:0];
		if (t < T_MIN) return T_MIN[COORD_W-1:0];
		return t[COORD_W-1:0];
	endfunction

	logic accept;
	logic [1:0] gap_q;

	logic   v_s1;
	coord_t eye_s1 [3];
	coord_t up_s1  [3];
	vcomp_t d_s1   [3];

	logic   vf;
	unit_t  f_n [3];
	logic   okf_n;
	coord_t eye_da [NORM_LAT][3];
	coord_t up_da  [NORM_LAT][3];

	logic v_p1, v_p2, v_p3, v_c1, v_c2;
	unit_t  f_p1 [3], f_p2 [3], f_p3 [3], f_c1 [3], f_c2 [3];
	logic   okf_p1, okf_p2, okf_p3, okf_c1, okf_c2;
	coord_t eye_p1 [3], eye_p2 [3], eye_p3 [3], eye_c1 [3], eye_c2 [3];
	mag_t   upm_p1 [3], upm_p2 [3];
	logic [2:0] upn_p1, upn_p2;
	mag_t   upmx_c;
	logic [POS_W-1:0] pos_p2;
	logic signed [SM_W:0] upsc_c [3];
	logic signed [SM_W:0] ups_p3 [3];
	logic signed [PF_W-1:0] prod_c1 [6];
	vcomp_t c_c2 [3];

	logic   vs;
	unit_t  s_n [3];
	logic   oks_n;
	unit_t  f_db   [NORM_LAT][3];
	coord_t eye_db [NORM_LAT][3];
	logic   okf_db [NORM_LAT];

	logic v_y1, v_y2, v_y3, v_y4;
	unit_t  s_y1 [3], s_y2 [3], s_y3 [3], s_y4 [3];
	unit_t  f_y1 [3], f_y2 [3], f_y3 [3], f_y4 [3];
	coord_t eye_y1 [3], eye_y2 [3];
	logic   deg_y1, deg_y2, deg_y3, deg_y4;
	logic signed [2*UNIT_W-1:0] psf_y1 [6];
	logic signed [UNIT_W+COORD_W-1:0] pse_y1 [3], pfe_y1 [3];
	logic signed [UD_W-1:0] ud_c [3];
	logic signed [U_W-1:0] u_y2 [3], u_y3 [3], u_y4 [3];
	logic signed [DP_W-1:0] sse_y2, sfe_y2, sue_y4;
	logic signed [U_W+COORD_W-1:0] pue_y3 [3];
	coord_t t0_y3, t2_y3, t0_y4, t2_y4;

	unit_t  bank_s_q [3], bank_f_q [3];
	logic signed [U_W-1:0] bank_u_q [3];
	coord_t bank_t0_q, bank_t1_q, bank_t2_q;
	logic   bank_deg_q;
	logic   active_q;
	logic [1:0] cnt_q;
	logic   strobe_q, deg_q, last_q;
	logic [1:0] row_q;
	coord_t col0_q, col1_q, col2_q, col3_q;

	assign busy   = gap_q != 2'd0;
	assign accept = start && !busy;

	lav_norm u_norm_f (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.in_vec   (d_s1),
		.out_valid(vf),
		.out_vec  (f_n),
		.out_ok   (okf_n)
	);

	lav_norm u_norm_s (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_c2),
		.in_vec   (c_c2),
		.out_valid(vs),
		.out_vec  (s_n),
		.out_ok   (oks_n)
	);

	always_comb begin
		upmx_c = upm_p1[0];
		if (upm_p1[1] > upmx_c) upmx_c = upm_p1[1];
		if (upm_p1[2] > upmx_c) upmx_c = upm_p1[2];
		for (int i = 0; i < 3; i++) begin
			upsc_c[i] = $signed({1'b0, scale_mag(upm_p2[i], pos_p2)});
			if (upn_p2[i]) upsc_c[i] = -upsc_c[i];
			ud_c[i] = UD_W'(psf_y1[2*i]) - UD_W'(psf_y1[2*i+1]) + UD_W'(HALF_LSB);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q    <= 2'd0;
			v_s1     <= 1'b0;
			v_p1     <= 1'b0;
			v_p2     <= 1'b0;
			v_p3     <= 1'b0;
			v_c1     <= 1'b0;
			v_c2     <= 1'b0;
			v_y1     <= 1'b0;
			v_y2     <= 1'b0;
			v_y3     <= 1'b0;
			v_y4     <= 1'b0;
			active_q <= 1'b0;
			cnt_q    <= ROW_SIDE;
			strobe_q <= 1'b0;
		end else begin
			if (accept) begin
				gap_q <= GAP_CYCLES;
			end else if (busy) begin
				gap_q <= gap_q - 2'd1;
			end
			v_s1 <= accept;
			v_p1 <= vf;
			v_p2 <= v_p1;
			v_p3 <= v_p2;
			v_c1 <= v_p3;
			v_c2 <= v_c1;
			v_y1 <= vs;
			v_y2 <= v_y1;
			v_y3 <= v_y2;
			v_y4 <= v_y3;
			strobe_q <= active_q;
			if (active_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == ROW_ORIGIN) active_q <= 1'b0;
			end
			if (v_y4) begin
				active_q <= 1'b1;
				cnt_q    <= ROW_SIDE;
			end
		end
	end

	always_ff @(posedge clk) begin
		eye_s1 <= '{eye_x, eye_y, eye_z};
		up_s1  <= '{up_x, up_y, up_z};
		d_s1[0] <= VEC_W'(target_x) - VEC_W'(eye_x);
		d_s1[1] <= VEC_W'(target_y) - VEC_W'(eye_y);
		d_s1[2] <= VEC_W'(target_z) - VEC_W'(eye_z);

		eye_da[0] <= eye_s1;
		up_da[0]  <= up_s1;
		for (int k = 1; k < NORM_LAT; k++) begin
			eye_da[k] <= eye_da[k-1];
			up_da[k]  <= up_da[k-1];
		end

		f_p1   <= f_n;
		okf_p1 <= okf_n;
		eye_p1 <= eye_da[NORM_LAT-1];
		for (int i = 0; i < 3; i++) begin
			upm_p1[i] <= mag_of(VEC_W'(up_da[NORM_LAT-1][i]));
			upn_p1[i] <= up_da[NORM_LAT-1][i][COORD_W-1];
		end
		f_p2   <= f_p1;
		okf_p2 <= okf_p1;
		eye_p2 <= eye_p1;
		upm_p2 <= upm_p1;
		upn_p2 <= upn_p1;
		pos_p2 <= msb_pos(upmx_c);
		f_p3   <= f_p2;
		okf_p3 <= okf_p2;
		eye_p3 <= eye_p2;
		ups_p3 <= upsc_c;

		prod_c1[0] <= f_p3[1] * ups_p3[2];
		prod_c1[1] <= f_p3[2] * ups_p3[1];
		prod_c1[2] <= f_p3[2] * ups_p3[0];
		prod_c1[3] <= f_p3[0] * ups_p3[2];
		prod_c1[4] <= f_p3[0] * ups_p3[1];
		prod_c1[5] <= f_p3[1] * ups_p3[0];
		f_c1   <= f_p3;
		okf_c1 <= okf_p3;
		eye_c1 <= eye_p3;
		for (int i = 0; i < 3; i++) c_c2[i] <= VEC_W'(prod_c1[2*i]) - VEC_W'(prod_c1[2*i+1]);
		f_c2   <= f_c1;
		okf_c2 <= okf_c1;
		eye_c2 <= eye_c1;

		f_db[0]   <= f_c2;
		eye_db[0] <= eye_c2;
		okf_db[0] <= okf_c2;
		for (int k = 1; k < NORM_LAT; k++) begin
			f_db[k]   <= f_db[k-1];
			eye_db[k] <= eye_db[k-1];
			okf_db[k] <= okf_db[k-1];
		end

		s_y1   <= s_n;
		f_y1   <= f_db[NORM_LAT-1];
		eye_y1 <= eye_db[NORM_LAT-1];
		deg_y1 <= !okf_db[NORM_LAT-1] || !oks_n;
		psf_y1[0] <= s_n[1] * f_db[NORM_LAT-1][2];
		psf_y1[1] <= s_n[2] * f_db[NORM_LAT-1][1];
		psf_y1[2] <= s_n[2] * f_db[NORM_LAT-1][0];
		psf_y1[3] <= s_n[0] * f_db[NORM_LAT-1][2];
		psf_y1[4] <= s_n[0] * f_db[NORM_LAT-1][1];
		psf_y1[5] <= s_n[1] * f_db[NORM_LAT-1][0];
		for (int i = 0; i < 3; i++) begin
			pse_y1[i] <= s_n[i] * eye_db[NORM_LAT-1][i];
			pfe_y1[i] <= f_db[NORM_LAT-1][i] * eye_db[NORM_LAT-1][i];
		end

		s_y2   <= s_y1;
		f_y2   <= f_y1;
		eye_y2 <= eye_y1;
		deg_y2 <= deg_y1;
		for (int i = 0; i < 3; i++) u_y2[i] <= ud_c[i][FRAC_BITS +: U_W];
		sse_y2 <= DP_W'(pse_y1[0]) + DP_W'(pse_y1[1]) + DP_W'(pse_y1[2]);
		sfe_y2 <= DP_W'(pfe_y1[0]) + DP_W'(pfe_y1[1]) + DP_W'(pfe_y1[2]);

		s_y3   <= s_y2;
		f_y3   <= f_y2;
		u_y3   <= u_y2;
		deg_y3 <= deg_y2;
		for (int i = 0; i < 3; i++) pue_y3[i] <= u_y2[i] * eye_y2[i];
		t0_y3  <= tr_out(sse_y2, 1'b1);
		t2_y3  <= tr_out(sfe_y2, 1'b0);

		s_y4   <= s_y3;
		f_y4   <= f_y3;
		u_y4   <= u_y3;
		deg_y4 <= deg_y3;
		t0_y4  <= t0_y3;
		t2_y4  <= t2_y3;
		sue_y4 <= DP_W'(pue_y3[0]) + DP_W'(pue_y3[1]) + DP_W'(pue_y3[2]);

		if (v_y4) begin
			bank_s_q   <= s_y4;
			bank_u_q   <= u_y4;
			bank_f_q   <= f_y4;
			bank_t0_q  <= t0_y4;
			bank_t1_q  <= tr_out(sue_y4, 1'b1);
			bank_t2_q  <= t2_y4;
			bank_deg_q <= deg_y4;
		end

		if (active_q) begin
			row_q  <= cnt_q;
			last_q <= cnt_q == ROW_ORIGIN;
			deg_q  <= bank_deg_q;
			case (cnt_q)
				ROW_SIDE: begin
					col0_q <= COORD_W'(bank_s_q[0]);
					col1_q <= COORD_W'(bank_s_q[1]);
					col2_q <= COORD_W'(bank_s_q[2]);
					col3_q <= bank_t0_q;
				end
				ROW_UP: begin
					col0_q <= COORD_W'(bank_u_q[0]);
					col1_q <= COORD_W'(bank_u_q[1]);
					col2_q <= COORD_W'(bank_u_q[2]);
					col3_q <= bank_t1_q;
				end
				ROW_FWD: begin
					col0_q <= -COORD_W'(bank_f_q[0]);
					col1_q <= -COORD_W'(bank_f_q[1]);
					col2_q <= -COORD_W'(bank_f_q[2]);
					col3_q <= bank_t2_q;
				end
				default: begin
					col0_q <= '0;
					col1_q <= '0;
					col2_q <= '0;
					col3_q <= ONE_Q;
				end
			endcase
		end
	end

	assign strobe     = strobe_q;
	assign row_index  = row_q;
	assign col0       = col0_q;
	assign col1       = col1_q;
	assign col2       = col2_q;
	assign col3       = col3_q;
	assign degenerate = deg_q;
	assign last_row   = last_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy low right after an item was taken");

	a_last_on_row3: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (last_row == (row_index == ROW_ORIGIN)))
		else $error("last_row does not match row 3");

	a_rows_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_row) |=> (strobe && (row_index == 2'($past(row_index) + 2'd1))))
		else $error("rows of an item not back to back in order");

	a_first_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !$past(strobe)) |-> (row_index == ROW_SIDE))
		else $error("item rows do not start at row 0");
`endif
endmodule
`default_nettype wire
